// File: rtl/core/vertical_jump_integrator_defines.svh
// ---------------------------------------------------------------------------
// vertical jump integrator assertion macros
// shared property wrappers for the port checker
// ---------------------------------------------------------------------------
`ifndef VERTICAL_JUMP_INTEGRATOR_DEFINES_SVH
`define VERTICAL_JUMP_INTEGRATOR_DEFINES_SVH

// same-cycle implication
`define VJI_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("vji check failed");

// next-cycle implication
`define VJI_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("vji check failed");

`endif

// File: rtl/core/vji_pkg.sv
// ---------------------------------------------------------------------------
// vji_pkg
// types and constants of the vertical jump integrator
// ---------------------------------------------------------------------------
package vji_pkg;

   localparam int DATA_W    = 32;
   localparam int FRAC_BITS = 12;
   localparam int DIV_BITS  = DATA_W - 1 + FRAC_BITS;
   localparam int DCNT_W    = $clog2(DIV_BITS);
   localparam int FALL_W    = 16;
   localparam int OP_W      = 3;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [OP_W-1:0] {
      OP_TICK   = 3'd0,
      OP_START  = 3'd1,
      OP_HEIGHT = 3'd2,
      OP_STOP   = 3'd3,
      OP_LOAD   = 3'd4,
      OP_PAUSE  = 3'd5
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEF_GRAVITY  = 3'd0,
      CSR_DEF_LAUNCH   = 3'd1,
      CSR_DEF_TERMINAL = 3'd2,
      CSR_ASC_GRAVITY  = 3'd3,
      CSR_ASC_LAUNCH   = 3'd4
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_VEL,
      ST_ACC,
      ST_DIV,
      ST_MUL,
      ST_TRIM,
      ST_FIN
   } state_type;

endpackage

// File: rtl/core/vertical_jump_integrator.sv
// Vertical jump integrator in signed 20.12 fixed point. Tick, start, stop, load position,
// set pause, and start-to-height with a height of zero or minus one finish without the
// solver, with the response registered the cycle after the request. A general
// start-to-height runs the ascent solver on one shared adder (velocity step, then height
// sum) for up to MAX_ASCENT_STEPS ascent steps, then trims any overshoot with a bit-serial
// divider, one 32x32 multiply and one subtract. A new request is taken while the block is
// idle and the response slot is free or being emptied.
// ---------------------------------------------------------------------------
// vertical_jump_integrator
// vertical motion integrator with iterative start-to-height solver
// ---------------------------------------------------------------------------
module vertical_jump_integrator
   import vji_pkg::*;
#(
   parameter int MAX_ASCENT_STEPS = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_W-1:0]      req_op,
   input  logic [DATA_W-1:0]    req_launch_velocity,
   input  logic [DATA_W-1:0]    req_target_height,
   input  logic [DATA_W-1:0]    req_gravity_in,
   input  logic [DATA_W-1:0]    req_terminal_in,
   input  logic [DATA_W-1:0]    req_position_in,
   input  logic [DATA_W-1:0]    req_height_in,
   input  logic                 req_pause_in,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [DATA_W-1:0]    rsp_z_out,
   output logic [DATA_W-1:0]    rsp_height_out,
   output logic [DATA_W-1:0]    rsp_velocity_out,
   output logic                 rsp_active_out,
   output logic [FALL_W-1:0]    rsp_fall_count_out,
   output logic [DATA_W-1:0]    rsp_start_z_out,
   output logic                 rsp_landed,
   output logic                 rsp_ascent_overflow
);

   localparam int STEP_W = $clog2(MAX_ASCENT_STEPS + 1);
   localparam logic [DATA_W-1:0] ALL_ONES = '1;

   state_type state_ff, state_in;

   logic [DATA_W-1:0] cfg_ff [5];

   logic [DATA_W-1:0] z_ff, z_in, h_ff, h_in, vel_ff, vel_in;
   logic [DATA_W-1:0] grav_ff, grav_in, term_ff, term_in, start_z_ff, start_z_in;
   logic              active_ff, active_in, paused_ff, paused_in;
   logic [FALL_W-1:0] fall_ff, fall_in;
   logic              landed_ff, landed_in, ovf_ff, ovf_in, rsp_valid_ff, rsp_valid_in;

   logic [DATA_W-1:0] svel_ff, svel_in, acc_ff, acc_in, tgt_ff, tgt_in;
   logic [DATA_W-1:0] sgrav_ff, sgrav_in, sterm_ff, sterm_in, dvs_ff, dvs_in;
   logic [DATA_W-1:0] rem_ff, rem_in, prod_ff, prod_in;
   logic [DIV_BITS-1:0] quo_ff, quo_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;
   logic [STEP_W-1:0] steps_ff, steps_in;
   logic              sovf_ff, sovf_in, dneg_ff, dneg_in;

   logic              accept, reached, solve_done, need_trim;
   logic [DATA_W-1:0] excess, g2, q32, trim, hsum, nvel;
   logic [DATA_W-1:0] step_a, step_b, step_sum;
   logic [DATA_W:0]   trial;
   logic              st_en;
   logic [DATA_W-1:0] st_vel, st_grav, st_term;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign reached    = (steps_ff != '0) && !($signed(acc_ff) < $signed(tgt_ff));
   assign solve_done = reached || (steps_ff == STEP_W'(MAX_ASCENT_STEPS));
   assign excess     = acc_ff - tgt_ff;
   assign need_trim  = ($signed(excess) > 0) && (svel_ff != '0);
   assign g2         = (req_gravity_in == ALL_ONES) ? cfg_ff[CSR_ASC_GRAVITY] : req_gravity_in;
   assign trial      = {rem_ff, quo_ff[DIV_BITS-1]};
   assign q32        = dneg_ff ? (DATA_W'(0) - quo_ff[DATA_W-1:0]) : quo_ff[DATA_W-1:0];
   assign trim       = DATA_W'($signed(prod_ff + (prod_ff[DATA_W-1] ? DATA_W'(4095) : '0))
                       >>> FRAC_BITS);
   assign hsum       = h_ff + vel_ff;
   assign nvel       = vel_ff - grav_ff;

   // shared ascent adder: velocity step, then height sum
   assign step_a   = (state_ff == ST_ACC) ? acc_ff : svel_ff;
   assign step_b   = (state_ff == ST_ACC) ? svel_ff : sgrav_ff;
   assign step_sum = step_a + step_b;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_op == OP_HEIGHT) && (req_target_height != '0)
                && (req_target_height != ALL_ONES)) begin
               state_in = ST_VEL;
            end
         end
         ST_VEL: begin
            if (solve_done) begin
               state_in = need_trim ? ST_DIV : ST_FIN;
            end else begin
               state_in = ST_ACC;
            end
         end
         ST_ACC:  state_in = ST_VEL;
         ST_DIV: begin
            if (dcnt_ff == DCNT_W'(DIV_BITS - 1)) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_TRIM;
         ST_TRIM: state_in = ST_FIN;
         ST_FIN:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath
   always_comb begin
      z_in = z_ff; h_in = h_ff; vel_in = vel_ff; grav_in = grav_ff; term_in = term_ff;
      start_z_in = start_z_ff; active_in = active_ff; paused_in = paused_ff;
      fall_in = fall_ff; landed_in = landed_ff; ovf_in = ovf_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      svel_in = svel_ff; acc_in = acc_ff; tgt_in = tgt_ff; sgrav_in = sgrav_ff;
      sterm_in = sterm_ff; dvs_in = dvs_ff; rem_in = rem_ff; prod_in = prod_ff;
      quo_in = quo_ff; dcnt_in = dcnt_ff; steps_in = steps_ff; sovf_in = sovf_ff;
      dneg_in = dneg_ff;
      st_en = 1'b0; st_vel = '0; st_grav = '0; st_term = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               landed_in    = 1'b0;
               ovf_in       = 1'b0;
               rsp_valid_in = 1'b1;
               unique case (req_op)
                  OP_TICK: begin
                     if (!paused_ff && active_ff) begin
                        if (vel_ff[DATA_W-1] && (fall_ff != '1)) begin
                           fall_in = fall_ff + 1'b1;
                        end
                        if (($signed(vel_ff) <= 0) && ($signed(hsum) <= 0)) begin
                           z_in       = z_ff - h_ff;
                           h_in       = '0;
                           active_in  = 1'b0;
                           paused_in  = 1'b0;
                           start_z_in = ALL_ONES;
                           landed_in  = 1'b1;
                        end else begin
                           h_in   = hsum;
                           z_in   = z_ff + vel_ff;
                           vel_in = (term_ff[DATA_W-1] && ($signed(nvel) < $signed(term_ff)))
                                    ? term_ff : nvel;
                        end
                     end
                  end
                  OP_START: begin
                     st_en = 1'b1; st_vel = req_launch_velocity;
                     st_grav = req_gravity_in; st_term = req_terminal_in;
                  end
                  OP_HEIGHT: begin
                     if (req_target_height == '0) begin
                        st_en = 1'b1; st_vel = '0;
                        st_grav = req_gravity_in; st_term = req_terminal_in;
                     end else if (req_target_height == ALL_ONES) begin
                        st_en = 1'b1; st_vel = cfg_ff[CSR_ASC_LAUNCH];
                        st_grav = g2; st_term = req_terminal_in;
                     end else begin
                        rsp_valid_in = 1'b0;
                        sgrav_in = g2; sterm_in = req_terminal_in;
                        tgt_in = req_target_height; svel_in = '0; acc_in = '0;
                        steps_in = '0; sovf_in = ($signed(g2) <= 0);
                     end
                  end
                  OP_STOP: begin
                     active_in = 1'b0; paused_in = 1'b0; start_z_in = ALL_ONES;
                  end
                  OP_LOAD: begin
                     z_in = req_position_in; h_in = req_height_in;
                  end
                  OP_PAUSE: paused_in = req_pause_in;
                  default: ;
               endcase
            end
         end
         ST_VEL: begin
            if (solve_done) begin
               sovf_in = sovf_ff || !reached;
               rem_in  = '0;
               quo_in  = {excess[DATA_W-2:0], FRAC_BITS'(0)};
               dneg_in = svel_ff[DATA_W-1];
               dvs_in  = svel_ff[DATA_W-1] ? (DATA_W'(0) - svel_ff) : svel_ff;
               dcnt_in = '0;
            end else begin
               svel_in  = step_sum;
               steps_in = steps_ff + 1'b1;
            end
         end
         ST_ACC: acc_in = step_sum;
         ST_DIV: begin
            if (trial >= {1'b0, dvs_ff}) begin
               rem_in = DATA_W'(trial - {1'b0, dvs_ff});
               quo_in = {quo_ff[DIV_BITS-2:0], 1'b1};
            end else begin
               rem_in = trial[DATA_W-1:0];
               quo_in = {quo_ff[DIV_BITS-2:0], 1'b0};
            end
            dcnt_in = dcnt_ff + 1'b1;
         end
         ST_MUL:  prod_in = sgrav_ff * q32;
         ST_TRIM: svel_in = svel_ff - trim;
         ST_FIN: begin
            st_en = 1'b1; st_vel = svel_ff; st_grav = sgrav_ff; st_term = sterm_ff;
            ovf_in = sovf_ff; rsp_valid_in = 1'b1;
         end
         default: ;
      endcase

      if (st_en) begin
         if (st_vel == '0) begin
            vel_in = DATA_W'(0) - cfg_ff[CSR_DEF_GRAVITY];
         end else if (st_vel == ALL_ONES) begin
            vel_in = cfg_ff[CSR_DEF_LAUNCH];
         end else begin
            vel_in = st_vel;
         end
         grav_in    = (st_grav == ALL_ONES) ? cfg_ff[CSR_DEF_GRAVITY] : st_grav;
         term_in    = (st_term == ALL_ONES) ? cfg_ff[CSR_DEF_TERMINAL] : st_term;
         active_in  = 1'b1;
         paused_in  = 1'b0;
         fall_in    = '0;
         start_z_in = z_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < 5; i++) begin
            cfg_ff[i] <= '0;
         end
         z_ff <= '0; h_ff <= '0; vel_ff <= '0; grav_ff <= '0; term_ff <= '0;
         start_z_ff <= ALL_ONES; active_ff <= 1'b0; paused_ff <= 1'b0; fall_ff <= '0;
         landed_ff <= 1'b0; ovf_ff <= 1'b0; rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_write_enable && (csr_index < CSR_IDX_W'(5))) begin
            cfg_ff[csr_index] <= csr_wdata;
         end
         z_ff <= z_in; h_ff <= h_in; vel_ff <= vel_in; grav_ff <= grav_in; term_ff <= term_in;
         start_z_ff <= start_z_in; active_ff <= active_in; paused_ff <= paused_in;
         fall_ff <= fall_in; landed_ff <= landed_in; ovf_ff <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      svel_ff <= svel_in; acc_ff <= acc_in; tgt_ff <= tgt_in; sgrav_ff <= sgrav_in;
      sterm_ff <= sterm_in; dvs_ff <= dvs_in; rem_ff <= rem_in; prod_ff <= prod_in;
      quo_ff <= quo_in; dcnt_ff <= dcnt_in; steps_ff <= steps_in; sovf_ff <= sovf_in;
      dneg_ff <= dneg_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_z_out           = z_ff;
   assign rsp_height_out      = h_ff;
   assign rsp_velocity_out    = vel_ff;
   assign rsp_active_out      = active_ff;
   assign rsp_fall_count_out  = fall_ff;
   assign rsp_start_z_out     = start_z_ff;
   assign rsp_landed          = landed_ff;
   assign rsp_ascent_overflow = ovf_ff;

endmodule

// File: rtl/core/vji_checker.sv
// ---------------------------------------------------------------------------
// vji_checker
// port-level checks of the vertical jump integrator
// ---------------------------------------------------------------------------
`include "vertical_jump_integrator_defines.svh"

module vji_checker
   import vji_pkg::*;
(
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_ready,
   input logic [OP_W-1:0]      req_op,
   input logic                 rsp_valid,
   input logic                 rsp_ready,
   input logic [DATA_W-1:0]    rsp_z_out,
   input logic [DATA_W-1:0]    rsp_height_out,
   input logic                 rsp_active_out,
   input logic [DATA_W-1:0]    rsp_start_z_out,
   input logic                 rsp_landed
);

   `VJI_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_z_out))
   `VJI_ASSERT_NEXT(a_stop_rsp, req_valid && req_ready && (req_op == OP_STOP),
      rsp_valid && !rsp_active_out && (rsp_start_z_out == '1))
   `VJI_ASSERT_NOW(a_landed_ground, rsp_valid && rsp_landed,
      !rsp_active_out && (rsp_height_out == '0))
   `VJI_ASSERT_NOW(a_no_overrun, req_ready, !rsp_valid || rsp_ready)

endmodule

bind vertical_jump_integrator vji_checker u_vji_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .req_op          (req_op),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_z_out       (rsp_z_out),
   .rsp_height_out  (rsp_height_out),
   .rsp_active_out  (rsp_active_out),
   .rsp_start_z_out (rsp_start_z_out),
   .rsp_landed      (rsp_landed)
);

// File: tb/tb_vertical_jump_integrator.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_vertical_jump_integrator
// self-checking bench: directed table then random motion sequences over several
// register settings, each response checked against the table or a local model
// ---------------------------------------------------------------------------
module tb_vertical_jump_integrator;
   import vji_pkg::*;

   localparam int ASCENT_LIMIT = 4096;
   localparam int WATCHDOG_LIMIT = 40000;
   localparam int RANDOM_PER_PHASE = 175;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [DATA_W-1:0] launch, target, gravity, terminal, position, height;
      logic              pause;
   } request_type;

   typedef struct {
      logic [DATA_W-1:0] z, height, velocity;
      logic              active;
      logic [FALL_W-1:0] fall_count;
      logic [DATA_W-1:0] start_z;
      logic              landed, overflow;
   } motion_type;

   typedef struct {
      request_type req;
      bit          typed;
      motion_type  want;
   } table_row_type;

   logic clock, reset;
   logic csr_write_enable;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [DATA_W-1:0] csr_wdata;
   logic req_valid, req_ready;
   logic [OP_W-1:0] req_op;
   logic [DATA_W-1:0] req_launch_velocity, req_target_height, req_gravity_in;
   logic [DATA_W-1:0] req_terminal_in, req_position_in, req_height_in;
   logic req_pause_in;
   logic rsp_valid, rsp_ready;
   logic [DATA_W-1:0] rsp_z_out, rsp_height_out, rsp_velocity_out, rsp_start_z_out;
   logic rsp_active_out, rsp_landed, rsp_ascent_overflow;
   logic [FALL_W-1:0] rsp_fall_count_out;

   vertical_jump_integrator DUT (.*);

   // model state
   logic [DATA_W-1:0] cfg_reg [5];
   logic [DATA_W-1:0] m_z, m_height, m_velocity, m_gravity, m_terminal, m_start_z;
   logic m_active, m_paused;
   logic [FALL_W-1:0] m_fall;

   motion_type expected_motion [$];
   int errors = 0;
   int accepted_reqs = 0;
   int checked_rsps = 0;
   int landings = 0;
   int overflows = 0;
   int idle_cycles = 0;
   int burst_left = 0;
   bit long_hold = 0;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic void stop_motion();
      m_active = 0;
      m_paused = 0;
      m_start_z = '1;
   endfunction

   function automatic void launch_motion(logic [31:0] vel, logic [31:0] grav,
                                         logic [31:0] term);
      if (vel == 0) vel = -cfg_reg[CSR_DEF_GRAVITY];
      else if (vel == '1) vel = cfg_reg[CSR_DEF_LAUNCH];
      m_velocity = vel;
      m_gravity = (grav == '1) ? cfg_reg[CSR_DEF_GRAVITY] : grav;
      m_terminal = (term == '1) ? cfg_reg[CSR_DEF_TERMINAL] : term;
      m_active = 1;
      m_paused = 0;
      m_fall = 0;
      m_start_z = m_z;
   endfunction

   function automatic bit tick_motion();
      if (m_paused || !m_active) return 0;
      m_height = m_height + m_velocity;
      m_z = m_z + m_velocity;
      if ($signed(m_velocity) < 0 && m_fall != '1) m_fall++;
      if ($signed(m_velocity) <= 0 && $signed(m_height) <= 0) begin
         m_z = m_z - m_height;
         m_height = 0;
         stop_motion();
         return 1;
      end
      m_velocity = m_velocity - m_gravity;
      if ($signed(m_terminal) < 0 && $signed(m_velocity) < $signed(m_terminal))
         m_velocity = m_terminal;
      return 0;
   endfunction

   function automatic bit solve_ascent(request_type r);
      logic [31:0] vel, grav, acc, excess, prod;
      longint quot;
      int steps;
      bit reached, ovf;
      vel = 0;
      ovf = 0;
      grav = r.gravity;
      if (r.target != 0) begin
         if (grav == '1) grav = cfg_reg[CSR_ASC_GRAVITY];
         if (r.target == '1) begin
            vel = cfg_reg[CSR_ASC_LAUNCH];
         end else begin
            acc = 0;
            steps = 0;
            reached = 0;
            if ($signed(grav) <= 0) ovf = 1;
            while (steps < ASCENT_LIMIT && !reached) begin
               vel = vel + grav;
               acc = acc + vel;
               steps++;
               if (!($signed(acc) < $signed(r.target))) reached = 1;
            end
            if (!reached) ovf = 1;
            excess = acc - r.target;
            if ($signed(excess) > 0 && vel != 0) begin
               quot = (longint'($signed(excess)) * 4096) / longint'($signed(vel));
               prod = grav * quot[31:0];
               vel = vel - 32'($signed(prod) / 4096);
            end
         end
      end
      launch_motion(vel, grav, r.terminal);
      return ovf;
   endfunction

   function automatic motion_type predict_motion(request_type r);
      motion_type o;
      o.landed = 0;
      o.overflow = 0;
      case (r.op)
         OP_TICK:   o.landed = tick_motion();
         OP_START:  launch_motion(r.launch, r.gravity, r.terminal);
         OP_HEIGHT: o.overflow = solve_ascent(r);
         OP_STOP:   stop_motion();
         OP_LOAD: begin
            m_z = r.position;
            m_height = r.height;
         end
         OP_PAUSE:  m_paused = r.pause;
         default: ;
      endcase
      o.z = m_z;
      o.height = m_height;
      o.velocity = m_velocity;
      o.active = m_active;
      o.fall_count = m_fall;
      o.start_z = m_start_z;
      return o;
   endfunction

   function automatic request_type make_req(logic [OP_W-1:0] op, logic [31:0] lv,
                                            logic [31:0] th, logic [31:0] gi,
                                            logic [31:0] ti, logic [31:0] pi,
                                            logic [31:0] hi, logic pz);
      request_type r;
      r.op = op; r.launch = lv; r.target = th; r.gravity = gi; r.terminal = ti;
      r.position = pi; r.height = hi; r.pause = pz;
      return r;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int pick;
      r = make_req(OP_W'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, 1'($urandom));
      if ($urandom_range(0, 4) == 0) begin
         // full-range noise, but keep unbounded ascent solves rare
         if (r.op == OP_HEIGHT && $urandom_range(0, 3) != 0) r.op = OP_TICK;
         return r;
      end
      pick = $urandom_range(0, 99);
      if (pick < 52) r.op = OP_TICK;
      else if (pick < 64) r.op = OP_START;
      else if (pick < 74) r.op = OP_HEIGHT;
      else if (pick < 78) r.op = OP_STOP;
      else if (pick < 87) r.op = OP_LOAD;
      else if (pick < 97) r.op = OP_PAUSE;
      else r.op = OP_W'($urandom_range(6, 7));
      r.launch = ($urandom_range(0, 7) == 0) ? '1 : $urandom_range(0, 60000);
      r.gravity = ($urandom_range(0, 7) == 0) ? '1 : $urandom_range(256, 16384);
      if ($urandom_range(0, 15) == 0) r.gravity = -$urandom_range(0, 100);
      r.terminal = ($urandom_range(0, 7) == 0) ? '1 : -$urandom_range(0, 40000);
      case ($urandom_range(0, 9))
         0: r.target = 0;
         1: r.target = '1;
         2: r.target = -$urandom_range(1, 100000);
         default: r.target = $urandom_range(1, 8000000);
      endcase
      r.height = $urandom_range(0, 200000);
      r.pause = ($urandom_range(0, 2) == 0);
      return r;
   endfunction

   task automatic send_request(request_type r, bit typed, motion_type want);
      motion_type got;
      int gap;
      req_valid <= 1;
      req_op <= r.op;
      req_launch_velocity <= r.launch;
      req_target_height <= r.target;
      req_gravity_in <= r.gravity;
      req_terminal_in <= r.terminal;
      req_position_in <= r.position;
      req_height_in <= r.height;
      req_pause_in <= r.pause;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      accepted_reqs++;
      got = predict_motion(r);
      expected_motion.push_back(typed ? want : got);
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                  : $urandom_range(1, 12);
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 0;
            repeat (gap) @(posedge clock);
         end
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain();
      req_valid <= 0;
      while (expected_motion.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_config(logic [DATA_W-1:0] vals [5]);
      for (int i = 0; i < 5; i++) begin
         csr_write_enable <= 1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         cfg_reg[i] = vals[i];
         @(posedge clock);
      end
      csr_write_enable <= 0;
      @(posedge clock);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t %s mismatch: expected %h actual %h", $time, name, want, got);
      end
   endtask

   // response checker
   always @(posedge clock) begin
      motion_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         checked_rsps++;
         if (expected_motion.size() == 0) begin
            errors++;
            $display("%0t unexpected response: expected none actual z=%h", $time,
                     rsp_z_out);
         end else begin
            w = expected_motion.pop_front();
            check_field("z", w.z, rsp_z_out);
            check_field("height", w.height, rsp_height_out);
            check_field("velocity", w.velocity, rsp_velocity_out);
            check_field("active", 32'(w.active), 32'(rsp_active_out));
            check_field("fall_count", 32'(w.fall_count), 32'(rsp_fall_count_out));
            check_field("start_z", w.start_z, rsp_start_z_out);
            check_field("landed", 32'(w.landed), 32'(rsp_landed));
            check_field("overflow", 32'(w.overflow), 32'(rsp_ascent_overflow));
            landings += w.landed;
            overflows += w.overflow;
         end
      end
   end

   // receiver stall pattern
   always @(posedge clock) begin
      int mode;
      mode = int'(($time / 768) % 4);
      if (long_hold) rsp_ready <= 0;
      else if (mode == 0) rsp_ready <= 1;
      else if (mode == 1) rsp_ready <= $urandom_range(0, 1);
      else if (mode == 2) rsp_ready <= ($urandom_range(0, 9) < 2);
      else rsp_ready <= ($urandom_range(0, 9) != 0);
   end

   // long receiver hold-off so the block backs up
   initial begin
      wait (accepted_reqs >= 500);
      @(posedge clock);
      long_hold <= 1;
      repeat (400) @(posedge clock);
      long_hold <= 0;
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired with %0d responses pending", expected_motion.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      table_row_type rows [$];
      logic [DATA_W-1:0] phase_cfg [5];
      motion_type zero_motion, loaded;
      zero_motion = '{z: 0, height: 0, velocity: 0, active: 0, fall_count: 0,
                      start_z: '1, landed: 0, overflow: 0};
      loaded = zero_motion;
      loaded.z = 32'h8000_0000;
      loaded.height = 32'h7fff_ffff;

      reset <= 1;
      csr_write_enable <= 0;
      csr_index <= 0;
      csr_wdata <= 0;
      req_valid <= 0;
      req_op <= OP_TICK;
      req_launch_velocity <= 0;
      req_target_height <= 0;
      req_gravity_in <= 0;
      req_terminal_in <= 0;
      req_position_in <= 0;
      req_height_in <= 0;
      req_pause_in <= 0;
      rsp_ready <= 0;
      for (int i = 0; i < 5; i++) cfg_reg[i] = 0;
      m_z = 0; m_height = 0; m_velocity = 0; m_gravity = 0; m_terminal = 0;
      m_active = 0; m_paused = 0; m_fall = 0; m_start_z = '1;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      phase_cfg = '{300, 20000, -30000, 400, 25000};
      write_config(phase_cfg);

      rows.push_back('{make_req(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 1, zero_motion});
      rows.push_back('{make_req(OP_STOP, 0, 0, 0, 0, 0, 0, 0), 1, zero_motion});
      rows.push_back('{make_req(OP_LOAD, 0, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 0),
                       1, loaded});
      rows.push_back('{make_req(OP_LOAD, '1, '1, '1, '1, 1000, 5000, 1), 0, zero_motion});
      rows.push_back('{make_req(OP_START, '1, 0, '1, '1, 0, 0, 0), 0, zero_motion});
      rows.push_back('{make_req(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 0, zero_motion});
      rows.push_back('{make_req(OP_PAUSE, 0, 0, 0, 0, 0, 0, 1), 0, zero_motion});
      rows.push_back('{make_req(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 0, zero_motion});
      rows.push_back('{make_req(OP_PAUSE, 0, 0, 0, 0, 0, 0, 0), 0, zero_motion});
      rows.push_back('{make_req(OP_START, 0, 0, 500, -8000, 0, 0, 0), 0, zero_motion});
      rows.push_back('{make_req(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 0, zero_motion});
      rows.push_back('{make_req(OP_START, 32'h8000_0000, 0, 32'h7fff_ffff,
                                32'h8000_0000, 0, 0, 0), 0, zero_motion});
      rows.push_back('{make_req(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 0, zero_motion});
      rows.push_back('{make_req(OP_START, 32'h7fff_ffff, 0, 32'h8000_0000,
                                32'h7fff_ffff, 0, 0, 0), 0, zero_motion});
      rows.push_back('{make_req(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 0, zero_motion});
      rows.push_back('{make_req(OP_HEIGHT, 0, 0, 777, -9000, 0, 0, 0), 0, zero_motion});
      rows.push_back('{make_req(OP_HEIGHT, 0, '1, '1, '1, 0, 0, 0), 0, zero_motion});
      rows.push_back('{make_req(OP_HEIGHT, 0, 400000, 1000, -5000, 0, 0, 0),
                       0, zero_motion});
      rows.push_back('{make_req(OP_HEIGHT, 0, 100000, 0, -5000, 0, 0, 0), 0, zero_motion});
      rows.push_back('{make_req(OP_HEIGHT, 0, 32'h7fff_ffff, 1, '1, 0, 0, 0),
                       0, zero_motion});
      rows.push_back('{make_req(OP_HEIGHT, 0, -50, '1, '1, 0, 0, 0), 0, zero_motion});
      rows.push_back('{make_req(3'd6, '1, '1, '1, '1, '1, '1, 1), 0, zero_motion});
      rows.push_back('{make_req(3'd7, 0, 0, 0, 0, 0, 0, 0), 0, zero_motion});
      rows.push_back('{make_req(OP_LOAD, 0, 0, 0, 0, 50, 0, 0), 0, zero_motion});
      rows.push_back('{make_req(OP_START, -100, 0, 10, -200, 0, 0, 0), 0, zero_motion});
      rows.push_back('{make_req(OP_TICK, 0, 0, 0, 0, 0, 0, 0), 0, zero_motion});
      foreach (rows[i]) send_request(rows[i].req, rows[i].typed, rows[i].want);
      drain();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: phase_cfg = '{250, 30000, -40000, 500, 30000};
            1: phase_cfg = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
                             32'h7fff_ffff, 32'h7fff_ffff};
            2: phase_cfg = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                             32'h8000_0000, 32'h8000_0000};
            3: phase_cfg = '{0, 0, 0, 0, 0};
            4: phase_cfg = '{$urandom, $urandom, $urandom, $urandom, $urandom};
            default: phase_cfg = '{1024, 12000, -15000, 2048, 12000};
         endcase
         write_config(phase_cfg);
         for (int n = 0; n < RANDOM_PER_PHASE; n++)
            send_request(random_request(), 0, zero_motion);
         drain();
      end

      $display("%0d requests over 7 register settings, %0d responses checked",
               accepted_reqs, checked_rsps);
      $display("%0d landings, %0d ascent overflows seen", landings, overflows);
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
